// ----- rtl/core/swept_sphere_collision_test_core_defines.svh -----
// Assertion macros used by the checker of the swept sphere collision core.
`ifndef SWEPT_SPHERE_COLLISION_TEST_CORE_DEFINES_SVH
`define SWEPT_SPHERE_COLLISION_TEST_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define SSCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ssct assertion failed");

// Concurrent assertion that is also checked while reset is held.
`define SSCT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ssct assertion failed");

`endif

// ----- rtl/core/ssct_pkg.sv -----
package ssct_pkg;

    // Field widths of the words on the ports.
    localparam int COORD_W = 16;
    localparam int RAD_W   = 15;

    // Datapath widths.
    localparam int DX_W    = COORD_W + 1;   // difference of start centers
    localparam int DY_W    = COORD_W + 2;   // difference of two motions
    localparam int RSUM_W  = RAD_W + 1;     // sum of the two radii
    localparam int OP_W    = DY_W + 1;      // signed multiplier operand
    localparam int PROD_W  = 2 * OP_W;
    localparam int ACC_W   = 37;            // dot product accumulators
    localparam int CHUNK_W = 18;            // half of a 36 bit magnitude
    localparam int WIDE_W  = 4 * CHUNK_W;   // exact squares and products
    localparam int FIN_W   = ACC_W + 3;     // final bound sum

    // Order in which the shared multiplier is used for one test.
    typedef enum logic [4:0] {
        ST_XY0,
        ST_XY1,
        ST_XY2,
        ST_YY0,
        ST_YY1,
        ST_YY2,
        ST_RR,
        ST_XX0,
        ST_XX1,
        ST_XX2,
        ST_PP_HH,
        ST_PP_HL,
        ST_PP_LL,
        ST_AC_HH,
        ST_AC_HL,
        ST_AC_LH,
        ST_AC_LL
    } mul_step_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic      load_a;
        logic      load_b;
        logic      issue;
        mul_step_t step;
        logic      finish;
    } ctrl_cmd_t;

endpackage

// ----- rtl/core/ssct_ctrl.sv -----
module ssct_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_pair_end,
    output logic                m_valid,
    input  logic                m_ready,
    output ssct_pkg::ctrl_cmd_t cmd
);

    ssct_pkg::ctrl_state_t state_reg, state_next;
    ssct_pkg::mul_step_t   step_reg, step_next;
    logic                  m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssct_pkg::S_IDLE;
            step_reg    <= ssct_pkg::ST_XY0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ssct_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_pair_end) begin
                        cmd.load_b = 1'b1;
                        step_next  = ssct_pkg::ST_XY0;
                        state_next = ssct_pkg::S_MUL;
                    end else begin
                        cmd.load_a = 1'b1;
                    end
                end
            end
            ssct_pkg::S_MUL: begin
                cmd.issue = 1'b1;
                cmd.step  = step_reg;
                if (step_reg == ssct_pkg::ST_AC_LL) begin
                    state_next = ssct_pkg::S_DRAIN;
                end else begin
                    step_next = ssct_pkg::mul_step_t'(step_reg + 5'd1);
                end
            end
            ssct_pkg::S_DRAIN: begin
                state_next = ssct_pkg::S_FINISH;
            end
            ssct_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ssct_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ssct_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/ssct_datapath.sv -----
module ssct_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [ssct_pkg::COORD_W-1:0]  s_last_x,
    input  logic signed [ssct_pkg::COORD_W-1:0]  s_last_y,
    input  logic signed [ssct_pkg::COORD_W-1:0]  s_last_z,
    input  logic signed [ssct_pkg::COORD_W-1:0]  s_now_x,
    input  logic signed [ssct_pkg::COORD_W-1:0]  s_now_y,
    input  logic signed [ssct_pkg::COORD_W-1:0]  s_now_z,
    input  logic        [ssct_pkg::RAD_W-1:0]    s_last_radius,
    input  ssct_pkg::ctrl_cmd_t                  cmd,
    output logic                                 m_hit
);

    localparam int CW = ssct_pkg::CHUNK_W;

    logic signed [ssct_pkg::COORD_W-1:0] in_last [3];
    logic signed [ssct_pkg::COORD_W-1:0] in_now  [3];

    // Held sphere A.
    logic signed [ssct_pkg::COORD_W-1:0] a_last_reg [3];
    logic signed [ssct_pkg::COORD_W-1:0] a_now_reg  [3];
    logic        [ssct_pkg::RAD_W-1:0]   a_rad_reg;

    // Relative start offset, relative motion and radius sum of the pair.
    logic signed [ssct_pkg::DX_W-1:0]    dx_reg [3];
    logic signed [ssct_pkg::DY_W-1:0]    dy_reg [3];
    logic        [ssct_pkg::RSUM_W-1:0]  rsum_reg;

    logic signed [ssct_pkg::OP_W-1:0]    op_a, op_b;
    logic signed [ssct_pkg::PROD_W-1:0]  prod_reg;
    logic                                acc_en_reg;
    ssct_pkg::mul_step_t                 acc_step_reg;
    logic signed [ssct_pkg::ACC_W-1:0]   prod_acc;
    logic        [ssct_pkg::WIDE_W-1:0]  prod_wide;

    // qa = Y.Y, negp = -X.Y, qc = X.X - R^2, sq = negp^2, ac = qa * qc.
    logic signed [ssct_pkg::ACC_W-1:0]   qa_reg, negp_reg, qc_reg;
    logic        [ssct_pkg::WIDE_W-1:0]  sq_reg, ac_reg;

    logic signed [ssct_pkg::FIN_W-1:0]   bound_sum;
    logic                                hit_now;
    logic                                hit_reg;

    assign in_last[0] = s_last_x;
    assign in_last[1] = s_last_y;
    assign in_last[2] = s_last_z;
    assign in_now[0]  = s_now_x;
    assign in_now[1]  = s_now_y;
    assign in_now[2]  = s_now_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                a_last_reg[i] <= '0;
                a_now_reg[i]  <= '0;
            end
            a_rad_reg <= '0;
        end else if (cmd.load_a) begin
            for (int i = 0; i < 3; i++) begin
                a_last_reg[i] <= in_last[i];
                a_now_reg[i]  <= in_now[i];
            end
            a_rad_reg <= s_last_radius;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_b) begin
            for (int i = 0; i < 3; i++) begin
                dx_reg[i] <= ssct_pkg::DX_W'(a_last_reg[i]) - ssct_pkg::DX_W'(in_last[i]);
                dy_reg[i] <= ssct_pkg::DY_W'(ssct_pkg::DX_W'(a_now_reg[i])
                                             - ssct_pkg::DX_W'(a_last_reg[i]))
                           - ssct_pkg::DY_W'(ssct_pkg::DX_W'(in_now[i])
                                             - ssct_pkg::DX_W'(in_last[i]));
            end
            rsum_reg <= ssct_pkg::RSUM_W'(a_rad_reg) + ssct_pkg::RSUM_W'(s_last_radius);
        end
    end

    // Operand selection for the shared signed multiplier. Wide magnitudes
    // are fed as two unsigned halves.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.step)
            ssct_pkg::ST_XY0: begin
                op_a = ssct_pkg::OP_W'(dx_reg[0]);
                op_b = ssct_pkg::OP_W'(dy_reg[0]);
            end
            ssct_pkg::ST_XY1: begin
                op_a = ssct_pkg::OP_W'(dx_reg[1]);
                op_b = ssct_pkg::OP_W'(dy_reg[1]);
            end
            ssct_pkg::ST_XY2: begin
                op_a = ssct_pkg::OP_W'(dx_reg[2]);
                op_b = ssct_pkg::OP_W'(dy_reg[2]);
            end
            ssct_pkg::ST_YY0: begin
                op_a = ssct_pkg::OP_W'(dy_reg[0]);
                op_b = ssct_pkg::OP_W'(dy_reg[0]);
            end
            ssct_pkg::ST_YY1: begin
                op_a = ssct_pkg::OP_W'(dy_reg[1]);
                op_b = ssct_pkg::OP_W'(dy_reg[1]);
            end
            ssct_pkg::ST_YY2: begin
                op_a = ssct_pkg::OP_W'(dy_reg[2]);
                op_b = ssct_pkg::OP_W'(dy_reg[2]);
            end
            ssct_pkg::ST_RR: begin
                op_a = $signed({3'b000, rsum_reg});
                op_b = $signed({3'b000, rsum_reg});
            end
            ssct_pkg::ST_XX0: begin
                op_a = ssct_pkg::OP_W'(dx_reg[0]);
                op_b = ssct_pkg::OP_W'(dx_reg[0]);
            end
            ssct_pkg::ST_XX1: begin
                op_a = ssct_pkg::OP_W'(dx_reg[1]);
                op_b = ssct_pkg::OP_W'(dx_reg[1]);
            end
            ssct_pkg::ST_XX2: begin
                op_a = ssct_pkg::OP_W'(dx_reg[2]);
                op_b = ssct_pkg::OP_W'(dx_reg[2]);
            end
            ssct_pkg::ST_PP_HH: begin
                op_a = $signed({1'b0, negp_reg[2*CW-1:CW]});
                op_b = $signed({1'b0, negp_reg[2*CW-1:CW]});
            end
            ssct_pkg::ST_PP_HL: begin
                op_a = $signed({1'b0, negp_reg[2*CW-1:CW]});
                op_b = $signed({1'b0, negp_reg[CW-1:0]});
            end
            ssct_pkg::ST_PP_LL: begin
                op_a = $signed({1'b0, negp_reg[CW-1:0]});
                op_b = $signed({1'b0, negp_reg[CW-1:0]});
            end
            ssct_pkg::ST_AC_HH: begin
                op_a = $signed({1'b0, qa_reg[2*CW-1:CW]});
                op_b = $signed({1'b0, qc_reg[2*CW-1:CW]});
            end
            ssct_pkg::ST_AC_HL: begin
                op_a = $signed({1'b0, qa_reg[2*CW-1:CW]});
                op_b = $signed({1'b0, qc_reg[CW-1:0]});
            end
            ssct_pkg::ST_AC_LH: begin
                op_a = $signed({1'b0, qa_reg[CW-1:0]});
                op_b = $signed({1'b0, qc_reg[2*CW-1:CW]});
            end
            ssct_pkg::ST_AC_LL: begin
                op_a = $signed({1'b0, qa_reg[CW-1:0]});
                op_b = $signed({1'b0, qc_reg[CW-1:0]});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= op_a * op_b;
        acc_step_reg <= cmd.step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.issue;
        end
    end

    assign prod_acc  = ssct_pkg::ACC_W'(prod_reg);
    assign prod_wide = ssct_pkg::WIDE_W'(prod_reg[2*CW-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.load_b) begin
            qa_reg   <= '0;
            negp_reg <= '0;
            qc_reg   <= '0;
            sq_reg   <= '0;
            ac_reg   <= '0;
        end else if (acc_en_reg) begin
            case (acc_step_reg)
                ssct_pkg::ST_XY0, ssct_pkg::ST_XY1, ssct_pkg::ST_XY2: begin
                    negp_reg <= negp_reg - prod_acc;
                end
                ssct_pkg::ST_YY0, ssct_pkg::ST_YY1, ssct_pkg::ST_YY2: begin
                    qa_reg <= qa_reg + prod_acc;
                end
                ssct_pkg::ST_RR: begin
                    qc_reg <= qc_reg - prod_acc;
                end
                ssct_pkg::ST_XX0, ssct_pkg::ST_XX1, ssct_pkg::ST_XX2: begin
                    qc_reg <= qc_reg + prod_acc;
                end
                ssct_pkg::ST_PP_HH: begin
                    sq_reg <= sq_reg + (prod_wide << (2 * CW));
                end
                ssct_pkg::ST_PP_HL: begin
                    // The cross term appears twice in a square.
                    sq_reg <= sq_reg + (prod_wide << (CW + 1));
                end
                ssct_pkg::ST_PP_LL: begin
                    sq_reg <= sq_reg + prod_wide;
                end
                ssct_pkg::ST_AC_HH: begin
                    ac_reg <= ac_reg + (prod_wide << (2 * CW));
                end
                ssct_pkg::ST_AC_HL, ssct_pkg::ST_AC_LH: begin
                    ac_reg <= ac_reg + (prod_wide << CW);
                end
                ssct_pkg::ST_AC_LL: begin
                    ac_reg <= ac_reg + prod_wide;
                end
                default: begin
                    qa_reg <= qa_reg;
                end
            endcase
        end
    end

    // a + b + c with b = -2 * negp.
    assign bound_sum = ssct_pkg::FIN_W'(qa_reg) + ssct_pkg::FIN_W'(qc_reg)
                     - (ssct_pkg::FIN_W'(negp_reg) <<< 1);

    // The squared terms are only meaningful when negp and qc are not negative,
    // which the first three terms require.
    assign hit_now = (qa_reg > 0) && !negp_reg[ssct_pkg::ACC_W-1]
                  && !qc_reg[ssct_pkg::ACC_W-1] && (sq_reg >= ac_reg)
                  && ((negp_reg <= qa_reg) || (bound_sum <= 0));

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            hit_reg <= hit_now;
        end
    end

    assign m_hit = hit_reg;

endmodule

// ----- rtl/core/swept_sphere_collision_test_core.sv -----
// Swept sphere first-contact test for pairs of spheres moving over one frame.
// Input channel (s_valid / s_ready): one word per sphere, carrying its previous
// and current centers in Q8.8 and its previous radius in unsigned Q7.8. A word
// with s_pair_end low is stored as sphere A and produces no result. A word
// with s_pair_end high is sphere B and starts the test against the held A,
// which stays held for further B words.
// Result channel (m_valid / m_ready): one word per test, m_hit high when the
// first contact time lies in [0,1]. After a B word is accepted, the controller
// runs the multiplier steps, a drain state and a finish state, then raises
// m_valid. The steps use one shared 19x19 multiplier that computes the three
// dot products and the exact 72 bit discriminant terms, one partial product
// per cycle, with a register after the multiplier.
// s_ready is high only while the controller is idle; it stays low for the
// whole test. The result sits in an output register, so a new word is taken
// while an earlier result waits. If the receiver stalls, a finished test waits
// until the output register frees up.
// Reset (aresetn, synchronous, active low) clears the held sphere A to zeros
// and drops m_valid.
module swept_sphere_collision_test_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ssct_pkg::COORD_W-1:0] s_last_x,
    input  logic signed [ssct_pkg::COORD_W-1:0] s_last_y,
    input  logic signed [ssct_pkg::COORD_W-1:0] s_last_z,
    input  logic signed [ssct_pkg::COORD_W-1:0] s_now_x,
    input  logic signed [ssct_pkg::COORD_W-1:0] s_now_y,
    input  logic signed [ssct_pkg::COORD_W-1:0] s_now_z,
    input  logic        [ssct_pkg::RAD_W-1:0]   s_last_radius,
    input  logic                                s_pair_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit
);

    ssct_pkg::ctrl_cmd_t cmd;

    // The controller sequences the multiplier steps and owns both handshakes.
    ssct_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pair_end (s_pair_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd)
    );

    // The datapath holds sphere A, the pair differences, the accumulators
    // and the result register.
    ssct_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_last_x      (s_last_x),
        .s_last_y      (s_last_y),
        .s_last_z      (s_last_z),
        .s_now_x       (s_now_x),
        .s_now_y       (s_now_y),
        .s_now_z       (s_now_z),
        .s_last_radius (s_last_radius),
        .cmd           (cmd),
        .m_hit         (m_hit)
    );

endmodule

// ----- rtl/core/ssct_checker.sv -----
`include "swept_sphere_collision_test_core_defines.svh"

module ssct_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_pair_end,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit
);

    // A stalled result holds its value.
    `SSCT_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_hit))

    // Reset leaves no result pending.
    `SSCT_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)

    // Storing sphere A never produces a result of its own.
    `SSCT_ASSERT(a_store_silent, aclk, aresetn, s_valid && s_ready && !s_pair_end && !m_valid |=> !m_valid)

    // A test word occupies the block, so the next word waits.
    `SSCT_ASSERT(a_test_busy, aclk, aresetn, s_valid && s_ready && s_pair_end |=> !s_ready)

endmodule

bind swept_sphere_collision_test_core ssct_checker u_ssct_checker (.*);
